>>> rtl/core/dpc_pkg.sv
package dpc_pkg;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] match_count;
    logic [31:0] gap_total;
  } out_item_t;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_MODE_FLAGS     = 3'd0,
    CFG_FIRST_PATTERN  = 3'd1,
    CFG_FIRST_LENGTH   = 3'd2,
    CFG_SECOND_PATTERN = 3'd3,
    CFG_SECOND_LENGTH  = 3'd4,
    CFG_SKIP_COUNT     = 3'd5,
    CFG_MATCH_LIMIT    = 3'd6
  } cfg_idx_t;

  localparam int MODE_NOCASE = 0;
  localparam int MODE_SET1   = 1;
  localparam int MODE_SET2   = 2;

  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

  // window cells to match logic
  typedef struct packed {
    logic exact1;
    logic exact2;
    logic set1;
    logic set2;
  } hits_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic nocase);
    logic [7:0] r;
    r = c;
    if (nocase && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/dpc_cell.sv
module dpc_cell #(
  parameter int P = 8,
  parameter int K = 0
) (
  input  logic                clk,
  input  logic                shift_en,
  input  logic [7:0]          din,
  input  logic [7:0]          cfold,
  input  logic [P-1:0][7:0]   pf1,
  input  logic [P-1:0][7:0]   pf2,
  input  logic [$clog2(P+1)-1:0] len1,
  input  logic [$clog2(P+1)-1:0] len2,
  output logic [7:0]          dout,
  output logic                ex1,
  output logic                ex2,
  output logic                set1,
  output logic                set2
);

  localparam int LW = $clog2(P + 1);
  localparam int IW = (P > 1) ? $clog2(P) : 1;

  logic [7:0]    q_r;
  logic [LW-1:0] pos1;
  logic [LW-1:0] pos2;
  logic          act1;
  logic          act2;

  // this cell holds window position K, which lines up with pattern byte len-1-K
  assign act1 = LW'(K) < len1;
  assign act2 = LW'(K) < len2;
  assign pos1 = len1 - LW'(K + 1);
  assign pos2 = len2 - LW'(K + 1);

  assign ex1  = !act1 || (din == pf1[pos1[IW-1:0]]);
  assign ex2  = !act2 || (din == pf2[pos2[IW-1:0]]);
  assign set1 = act1 && (cfold == pf1[K]);
  assign set2 = act2 && (cfold == pf2[K]);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= din;
    end
  end

  assign dout = q_r;

endmodule

>>> rtl/core/dpc_window.sv
module dpc_window #(
  parameter int P = 8
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [7:0]             src_byte,
  input  logic                   nocase,
  input  logic [63:0]            pat1,
  input  logic [63:0]            pat2,
  input  logic [$clog2(P+1)-1:0] len1,
  input  logic [$clog2(P+1)-1:0] len2,
  output dpc_pkg::hits_t         hits
);

  logic [7:0]         cfold;
  logic [P-1:0][7:0]  pf1;
  logic [P-1:0][7:0]  pf2;
  logic [P-1:0][7:0]  chain;
  logic [P-1:0]       ex1;
  logic [P-1:0]       ex2;
  logic [P-1:0]       set1;
  logic [P-1:0]       set2;

  assign cfold = dpc_pkg::fold_byte(src_byte, nocase);

  for (genvar k = 0; k < P; k++) begin : g_cell
    logic [7:0] din;

    assign pf1[k] = dpc_pkg::fold_byte(pat1[8*k +: 8], nocase);
    assign pf2[k] = dpc_pkg::fold_byte(pat2[8*k +: 8], nocase);

    if (k == 0) begin : g_head
      assign din = cfold;
    end else begin : g_body
      assign din = chain[k-1];
    end

    dpc_cell #(.P(P), .K(k)) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .din      (din),
      .cfold    (cfold),
      .pf1      (pf1),
      .pf2      (pf2),
      .len1     (len1),
      .len2     (len2),
      .dout     (chain[k]),
      .ex1      (ex1[k]),
      .ex2      (ex2[k]),
      .set1     (set1[k]),
      .set2     (set2[k])
    );
  end

  assign hits.exact1 = &ex1;
  assign hits.exact2 = &ex2;
  assign hits.set1   = |set1;
  assign hits.set2   = |set2;

endmodule

>>> rtl/core/dpc_ctrl.sv
module dpc_ctrl #(
  parameter int P = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dpc_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dpc_pkg::out_item_t     out_data,
  input  dpc_pkg::hits_t         hits,
  input  logic [$clog2(P+1)-1:0] len1,
  input  logic [$clog2(P+1)-1:0] len2,
  input  logic [2:0]             mode,
  input  logic [31:0]            skip,
  input  logic [31:0]            limit,
  output logic                   shift_en
);

  localparam int LW = $clog2(P + 1);

  logic [LW-1:0] fresh_r, fresh_nxt, fresh_inc;
  logic          await_r, await_nxt;
  logic [31:0]   bidx_r, bidx_nxt;
  logic [31:0]   fend_r, fend_nxt;
  logic [31:0]   count_r, count_nxt, count_inc;
  logic [31:0]   gsum_r, gsum_nxt;
  logic          lim_r, lim_nxt, lim_reach;
  logic          out_valid_r;
  dpc_pkg::out_item_t out_r;

  logic          fire;
  logic          hit1, hit2;
  logic [31:0]   start;
  logic [32:0]   gdiff;
  logic [31:0]   gap;
  logic [32:0]   gadd;

  assign in_ready  = !out_valid_r || out_ready || !in_data.last_byte;
  assign fire      = in_valid && in_ready;
  assign shift_en  = fire && !lim_r && (bidx_r >= skip);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign fresh_inc = (fresh_r == LW'(P)) ? fresh_r : fresh_r + LW'(1);

  assign hit1 = mode[dpc_pkg::MODE_SET1] ? hits.set1 :
                ((len1 != '0) && (fresh_inc >= len1) && hits.exact1);
  assign hit2 = mode[dpc_pkg::MODE_SET2] ? hits.set2 :
                ((len2 != '0) && (fresh_inc >= len2) && hits.exact2);

  // second match starts len2-1 bytes back in exact mode
  assign start = mode[dpc_pkg::MODE_SET2] ? bidx_r : bidx_r - 32'(len2) + 32'd1;
  assign gdiff = {1'b0, start} - {1'b0, fend_r};
  assign gap   = gdiff[32] ? 32'd0 : gdiff[31:0];
  assign gadd  = {1'b0, gsum_r} + {1'b0, gap};

  assign count_inc = (count_r == dpc_pkg::ALL32) ? count_r : count_r + 32'd1;
  assign lim_reach = (limit != 32'd0) && (count_inc == limit);

  always_comb begin
    bidx_nxt  = bidx_r;
    fresh_nxt = fresh_r;
    await_nxt = await_r;
    fend_nxt  = fend_r;
    count_nxt = count_r;
    gsum_nxt  = gsum_r;
    lim_nxt   = lim_r;
    if (fire && bidx_r != dpc_pkg::ALL32) begin
      bidx_nxt = bidx_r + 32'd1;
    end
    if (shift_en) begin
      fresh_nxt = fresh_inc;
      if (!await_r) begin
        if (hit1) begin
          fresh_nxt = '0;
          fend_nxt  = (bidx_r == dpc_pkg::ALL32) ? bidx_r : bidx_r + 32'd1;
          if (len2 != '0) begin
            await_nxt = 1'b1;
          end else begin
            count_nxt = count_inc;
            lim_nxt   = lim_r || lim_reach;
          end
        end
      end else if (hit2) begin
        gsum_nxt  = gadd[32] ? dpc_pkg::ALL32 : gadd[31:0];
        await_nxt = 1'b0;
        fresh_nxt = '0;
        count_nxt = count_inc;
        lim_nxt   = lim_r || lim_reach;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bidx_r      <= '0;
      fresh_r     <= '0;
      await_r     <= 1'b0;
      fend_r      <= '0;
      count_r     <= '0;
      gsum_r      <= '0;
      lim_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && in_data.last_byte) begin
        // report totals and clear for the next string
        bidx_r      <= '0;
        fresh_r     <= '0;
        await_r     <= 1'b0;
        fend_r      <= '0;
        count_r     <= '0;
        gsum_r      <= '0;
        lim_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        bidx_r  <= bidx_nxt;
        fresh_r <= fresh_nxt;
        await_r <= await_nxt;
        fend_r  <= fend_nxt;
        count_r <= count_nxt;
        gsum_r  <= gsum_nxt;
        lim_r   <= lim_nxt;
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_data.last_byte) begin
      out_r.match_count <= count_nxt;
      out_r.gap_total   <= gsum_nxt;
    end
  end

endmodule

>>> rtl/core/delimited_pair_counter.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | dpc_pkg::in_item_t (src_byte, last_byte)
// out_    | output    | out_valid / out_ready| dpc_pkg::out_item_t (match_count, gap_total)
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index (3 bits), cfg_data (64 bits)
//
// One source byte per cycle; the pattern compare across the cell row and the
// gap arithmetic both finish in the cycle the byte is taken.
// The result of a string is registered and appears in the cycle after its last byte is taken.
// Bytes that are not last are taken even while a result waits on out_ready;
// a last byte waits until the output register is free.
// Reset (synchronous, rst_n low) zeroes config, counters and out_valid, not out_data.
module delimited_pair_counter #(
  parameter int MAX_PATTERN_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dpc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dpc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);

  logic [2:0]    mode_r;
  logic [63:0]   pat1_r;
  logic [3:0]    len1_r;
  logic [63:0]   pat2_r;
  logic [3:0]    len2_r;
  logic [31:0]   skip_r;
  logic [31:0]   limit_r;

  logic [LW-1:0] len1;
  logic [LW-1:0] len2;
  logic          shift_en;
  dpc_pkg::hits_t hits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      pat1_r  <= '0;
      len1_r  <= '0;
      pat2_r  <= '0;
      len2_r  <= '0;
      skip_r  <= '0;
      limit_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dpc_pkg::CFG_MODE_FLAGS:     mode_r  <= cfg_data[2:0];
        dpc_pkg::CFG_FIRST_PATTERN:  pat1_r  <= cfg_data;
        dpc_pkg::CFG_FIRST_LENGTH:   len1_r  <= cfg_data[3:0];
        dpc_pkg::CFG_SECOND_PATTERN: pat2_r  <= cfg_data;
        dpc_pkg::CFG_SECOND_LENGTH:  len2_r  <= cfg_data[3:0];
        dpc_pkg::CFG_SKIP_COUNT:     skip_r  <= cfg_data[31:0];
        dpc_pkg::CFG_MATCH_LIMIT:    limit_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // clamp lengths to the cell count
  assign len1 = (len1_r > 4'(MAX_PATTERN_BYTES)) ? LW'(MAX_PATTERN_BYTES) : len1_r[LW-1:0];
  assign len2 = (len2_r > 4'(MAX_PATTERN_BYTES)) ? LW'(MAX_PATTERN_BYTES) : len2_r[LW-1:0];

  dpc_window #(.P(MAX_PATTERN_BYTES)) u_window (
    .clk      (clk),
    .shift_en (shift_en),
    .src_byte (in_data.src_byte),
    .nocase   (mode_r[dpc_pkg::MODE_NOCASE]),
    .pat1     (pat1_r),
    .pat2     (pat2_r),
    .len1     (len1),
    .len2     (len2),
    .hits     (hits)
  );

  dpc_ctrl #(.P(MAX_PATTERN_BYTES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .hits      (hits),
    .len1      (len1),
    .len2      (len2),
    .mode      (mode_r),
    .skip      (skip_r),
    .limit     (limit_r),
    .shift_en  (shift_en)
  );

endmodule

>>> rtl/core/dpc_chk.sv
module dpc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input dpc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input dpc_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [63:0]        cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a last-byte transaction always yields a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=> out_valid)
    else $error("no result after last byte");

  // bytes other than the last never stall
  a_body_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_data.last_byte |-> in_ready)
    else $error("non-last byte stalled");

  // a full, stalled output blocks the next last byte
  a_last_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_data.last_byte |-> !in_ready)
    else $error("last byte taken over a pending result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delimited_pair_counter dpc_chk u_dpc_chk (.*);
